// File: rtl/gcg_pkg.sv
// Package for the glyph column generator: request mode codes, controller
// command bytes, per-request last-beat indices and the 5x7 font ROM contents.
// No dependencies.
`timescale 1ns / 1ps

package gcg_pkg;

    // Request modes on the input channel.
    localparam logic [1:0] MODE_CHAR   = 2'd0;
    localparam logic [1:0] MODE_CURSOR = 2'd1;
    localparam logic [1:0] MODE_RAW    = 2'd2;

    // Printable code range covered by the font.
    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] LAST_CODE  = 8'h7E;

    // Attribute value that inverts the whole character cell.
    localparam logic [7:0] INVERT_ATTR = 8'hFF;

    // Controller address commands.
    localparam logic [7:0] CMD_SET_COLUMN = 8'h80;
    localparam logic [7:0] CMD_SET_ROW    = 8'h40;

    // Font geometry.
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_COUNT = 95;

    // Index of the final output word of each request kind.
    localparam logic [2:0] CHAR_LAST_BEAT   = 3'd5;
    localparam logic [2:0] CURSOR_LAST_BEAT = 3'd1;
    localparam logic [2:0] RAW_LAST_BEAT    = 3'd0;

    // One font entry holds the five columns, leftmost column in the top byte.
    typedef logic [8*GLYPH_COLS-1:0] glyph_t;

    localparam glyph_t GLYPH_ROM [0:GLYPH_COUNT-1] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008
    };

endpackage

// File: rtl/glyph_column_generator.sv
// Glyph column generator top level: request register, synchronous font ROM
// and the output word sequencer. Depends on gcg_pkg.
`timescale 1ns / 1ps

// Usage:
// The s_ channel takes one request per word (mode, code, attribute, row,
// column); the m_ channel gives controller bytes with a D/C flag and a last
// flag on the final byte of each request.
// A character request (codes 0x20 to 0x7E) gives six data words: five font
// columns and a blank column, inverted when the attribute is 0xFF and ORed
// with the attribute otherwise. A cursor request gives two command words, a
// raw request one data word. Out-of-range codes and mode 3 are taken and
// dropped without output.
// The font ROM is read into the request register at the accepting edge, and the
// output register loads the first word from it once the output is free.
// Throughput: one output word per cycle while the receiver is ready. The next
// request is taken in the cycle the current one loads its last word, so requests
// follow without gaps.
// Reset clears the request and output valid flags; no words are pending.
// When the receiver stalls, the output register holds its word and the
// request in progress waits, so s_ready drops once that request is loaded.
module glyph_column_generator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_code,
    input  logic [7:0] s_attribute,
    input  logic [2:0] s_row,
    input  logic [6:0] s_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out,
    output logic       m_is_data,
    output logic       m_last
);

    // Request register (payload) and its control.
    logic                 req_valid_reg, req_valid_next;
    logic [2:0]           beat_reg, beat_next;
    logic [2:0]           last_beat_reg;
    logic [1:0]           mode_reg;
    logic [7:0]           code_reg;
    logic [7:0]           attr_reg;
    logic [2:0]           row_reg;
    logic [6:0]           column_reg;
    gcg_pkg::glyph_t      rom_data_reg;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 is_data_reg, is_data_next;
    logic                 last_reg, last_next;

    logic                 s_fire;
    logic                 out_load;
    logic                 req_done;
    logic                 char_in_range;
    logic                 produces;
    logic [2:0]           new_last_beat;
    logic [6:0]           rom_addr;
    logic [7:0]           glyph_col;

    // Handshake decisions.
    assign out_load = req_valid_reg && (!out_valid_reg || m_ready);
    assign req_done = out_load && (beat_reg == last_beat_reg);
    assign s_ready  = !req_valid_reg || req_done;
    assign s_fire   = s_valid && s_ready;

    // Classify the incoming request.
    assign char_in_range = (s_code >= gcg_pkg::FIRST_CODE) && (s_code <= gcg_pkg::LAST_CODE);

    always_comb begin
        produces      = 1'b0;
        new_last_beat = gcg_pkg::RAW_LAST_BEAT;
        case (s_mode)
            gcg_pkg::MODE_CHAR: begin
                produces      = char_in_range;
                new_last_beat = gcg_pkg::CHAR_LAST_BEAT;
            end
            gcg_pkg::MODE_CURSOR: begin
                produces      = 1'b1;
                new_last_beat = gcg_pkg::CURSOR_LAST_BEAT;
            end
            gcg_pkg::MODE_RAW: begin
                produces      = 1'b1;
                new_last_beat = gcg_pkg::RAW_LAST_BEAT;
            end
            default: begin
                produces      = 1'b0;
                new_last_beat = gcg_pkg::RAW_LAST_BEAT;
            end
        endcase
    end

    // Font ROM address, held at entry zero for codes outside the font.
    assign rom_addr = char_in_range ? 7'(s_code - gcg_pkg::FIRST_CODE) : 7'd0;

    // Request sequencing: a new request starts at beat zero, else step on each load.
    always_comb begin
        req_valid_next = req_valid_reg;
        beat_next      = beat_reg;
        if (req_done) begin
            req_valid_next = 1'b0;
        end else if (out_load) begin
            beat_next = beat_reg + 3'd1;
        end
        if (s_fire && produces) begin
            req_valid_next = 1'b1;
            beat_next      = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
        end else begin
            req_valid_reg <= req_valid_next;
            beat_reg      <= beat_next;
        end
    end

    // Request payload and synchronous font ROM read, captured on acceptance.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mode_reg      <= s_mode;
            code_reg      <= s_code;
            attr_reg      <= s_attribute;
            row_reg       <= s_row;
            column_reg    <= s_column;
            last_beat_reg <= new_last_beat;
            rom_data_reg  <= gcg_pkg::GLYPH_ROM[rom_addr];
        end
    end

    // Column of the glyph for the current beat; the spacing column is blank.
    always_comb begin
        case (beat_reg)
            3'd0:    glyph_col = rom_data_reg[39:32];
            3'd1:    glyph_col = rom_data_reg[31:24];
            3'd2:    glyph_col = rom_data_reg[23:16];
            3'd3:    glyph_col = rom_data_reg[15:8];
            3'd4:    glyph_col = rom_data_reg[7:0];
            default: glyph_col = 8'h00;
        endcase
    end

    // Output word formation and output register control.
    always_comb begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        is_data_next   = is_data_reg;
        last_next      = last_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
            last_next      = (beat_reg == last_beat_reg);
            case (mode_reg)
                gcg_pkg::MODE_CHAR: begin
                    is_data_next = 1'b1;
                    if (attr_reg == gcg_pkg::INVERT_ATTR) begin
                        byte_next = ~glyph_col;
                    end else begin
                        byte_next = glyph_col | attr_reg;
                    end
                end
                gcg_pkg::MODE_CURSOR: begin
                    is_data_next = 1'b0;
                    if (beat_reg == 3'd0) begin
                        byte_next = gcg_pkg::CMD_SET_COLUMN | {1'b0, column_reg};
                    end else begin
                        byte_next = gcg_pkg::CMD_SET_ROW | {5'b0, row_reg};
                    end
                end
                default: begin
                    is_data_next = 1'b1;
                    byte_next    = code_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        is_data_reg <= is_data_next;
        last_reg    <= last_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_byte_out = byte_reg;
    assign m_is_data  = is_data_reg;
    assign m_last     = last_reg;

    // The beat counter never passes the final word of the active request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg |-> (beat_reg <= last_beat_reg))
        else $error("beat counter ran past the last word of the request");

    // A request is taken while one is pending only as that one loads its last word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && req_valid_reg) |-> (out_load && (beat_reg == last_beat_reg)))
        else $error("request accepted over an unfinished request");

    // Command words always carry an address command bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_data) |-> (m_byte_out[7] || m_byte_out[6]))
        else $error("command word without an address command bit");

    // A loaded last word leaves no request behind unless a new one was taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (req_done && !s_fire) |=> !req_valid_reg)
        else $error("request still active after its last word");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for glyph_column_generator: a directed table of
// requests, then random requests under random idling on both channels.
// Depends on gcg_pkg and the glyph_column_generator RTL.
`timescale 1ns / 1ps

module tb_top;

    // Mode 3 carries no meaning and must be dropped by the block.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Marks a table row whose words come from the predictor.
    localparam logic [3:0] PREDICTED = 4'hF;
    localparam int RANDOM_REQUESTS = 248;
    localparam int TAIL_CYCLES = 12;
    localparam int DRAIN_LIMIT = 4000;

    // Independent copy of the 5x7 font, leftmost column in the top byte.
    localparam logic [39:0] FONT_5X7 [0:94] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008
    };

    // One controller word as it should appear on the m_ channel.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_data;
        logic       last;
    } ctrl_word_t;

    // One request, with optional hand-written words (first word in the top byte).
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  code;
        logic [7:0]  attribute;
        logic [2:0]  row;
        logic [6:0]  column;
        logic [3:0]  fixed_n;
        logic [47:0] fixed_bytes;
        logic        fixed_data;
    } request_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [7:0] s_code;
    logic [7:0] s_attribute;
    logic [2:0] s_row;
    logic [6:0] s_column;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_byte_out;
    logic       m_is_data;
    logic       m_last;

    ctrl_word_t pending_ctrl_words [$];
    request_t   directed [$];
    int         error_count;
    int         words_checked;
    int         n_char;
    int         n_cursor;
    int         n_raw;
    int         n_dropped;
    logic       rx_steady;

    glyph_column_generator DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_code      (s_code),
        .s_attribute (s_attribute),
        .s_row       (s_row),
        .s_column    (s_column),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_byte_out  (m_byte_out),
        .m_is_data   (m_is_data),
        .m_last      (m_last)
    );

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Work out the controller words of one request and queue them.
    function automatic void render_request(input request_t r);
        logic [39:0] cols;
        logic [7:0]  colbits;
        ctrl_word_t  w;
        case (r.mode)
            gcg_pkg::MODE_CHAR: begin
                if (r.code >= gcg_pkg::FIRST_CODE && r.code <= gcg_pkg::LAST_CODE) begin
                    cols = FONT_5X7[7'(r.code - gcg_pkg::FIRST_CODE)];
                    for (int k = 0; k <= int'(gcg_pkg::CHAR_LAST_BEAT); k++) begin
                        colbits = (k < gcg_pkg::GLYPH_COLS) ? cols[39 - 8*k -: 8] : 8'h00;
                        w.byte_val = (r.attribute == gcg_pkg::INVERT_ATTR)
                                     ? ~colbits : (colbits | r.attribute);
                        w.is_data = 1'b1;
                        w.last = (k == int'(gcg_pkg::CHAR_LAST_BEAT));
                        pending_ctrl_words.push_back(w);
                    end
                end
            end
            gcg_pkg::MODE_CURSOR: begin
                pending_ctrl_words.push_back('{gcg_pkg::CMD_SET_COLUMN | {1'b0, r.column},
                                               1'b0, 1'b0});
                pending_ctrl_words.push_back('{gcg_pkg::CMD_SET_ROW | {5'b0, r.row},
                                               1'b0, 1'b1});
            end
            gcg_pkg::MODE_RAW: begin
                pending_ctrl_words.push_back('{r.code, 1'b1, 1'b1});
            end
            default: begin
            end
        endcase
    endfunction

    // Build a table row; n = PREDICTED leaves the words to the predictor.
    function automatic request_t req(input logic [1:0] m, input logic [7:0] c,
                                     input logic [7:0] a, input logic [2:0] r,
                                     input logic [6:0] col, input logic [3:0] n,
                                     input logic [47:0] b, input logic d);
        request_t q;
        q = '{m, c, a, r, col, n, b, d};
        return q;
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // A random request, half of them valid characters with varied attributes.
    function automatic request_t random_request();
        request_t q;
        int p;
        int pa;
        q.code = 8'($urandom);
        q.attribute = 8'($urandom);
        q.row = 3'($urandom);
        q.column = 7'($urandom);
        q.fixed_n = PREDICTED;
        q.fixed_bytes = '0;
        q.fixed_data = 1'b0;
        p = $urandom_range(0, 99);
        if (p < 50) begin
            q.mode = gcg_pkg::MODE_CHAR;
            q.code = 8'($urandom_range(gcg_pkg::FIRST_CODE, gcg_pkg::LAST_CODE));
            pa = $urandom_range(0, 99);
            if (pa < 15) q.attribute = gcg_pkg::INVERT_ATTR;
            else if (pa < 30) q.attribute = 8'h00;
            else if (pa < 50) q.attribute = 8'h01 << $urandom_range(0, 7);
        end else if (p < 65) begin
            q.mode = gcg_pkg::MODE_CURSOR;
        end else if (p < 80) begin
            q.mode = gcg_pkg::MODE_RAW;
        end else if (p < 92) begin
            q.mode = gcg_pkg::MODE_CHAR;
            q.code = $urandom_range(0, 1)
                     ? 8'($urandom_range(8'h00, gcg_pkg::FIRST_CODE - 1))
                     : 8'($urandom_range(gcg_pkg::LAST_CODE + 1, 8'hFF));
        end else begin
            q.mode = MODE_UNUSED;
        end
        return q;
    endfunction

    // Present one request word and hold it until it is taken.
    task automatic send_request(input request_t r);
        @(negedge aclk);
        s_valid = 1'b1;
        s_mode = r.mode;
        s_code = r.code;
        s_attribute = r.attribute;
        s_row = r.row;
        s_column = r.column;
        do @(posedge aclk); while (!s_ready);
        if (r.fixed_n == PREDICTED) begin
            render_request(r);
        end else begin
            for (int k = 0; k < int'(r.fixed_n); k++) begin
                pending_ctrl_words.push_back('{r.fixed_bytes[47 - 8*k -: 8], r.fixed_data,
                                               k == int'(r.fixed_n) - 1});
            end
        end
        if (r.mode == gcg_pkg::MODE_CURSOR) n_cursor++;
        else if (r.mode == gcg_pkg::MODE_RAW) n_raw++;
        else if (r.mode == gcg_pkg::MODE_CHAR && r.code >= gcg_pkg::FIRST_CODE
                 && r.code <= gcg_pkg::LAST_CODE)
            n_char++;
        else n_dropped++;
    endtask

    // Drop valid after an accepted word, for an idle stretch set by n.
    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Receiver: ready runs broken by stalls, steady when asked.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            m_ready = 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            stall = rand_gap();
            while (stall > 0 && !rx_steady) begin
                @(negedge aclk);
                m_ready = 1'b0;
                stall--;
            end
        end
    end

    // Compare each accepted word with the oldest expected one.
    always @(posedge aclk) begin
        ctrl_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_ctrl_words.size() == 0) begin
                $error("unexpected word: byte_out 0x%02h is_data %0b last %0b",
                       m_byte_out, m_is_data, m_last);
                error_count++;
            end else begin
                w = pending_ctrl_words.pop_front();
                words_checked++;
                if (m_byte_out !== w.byte_val) begin
                    $error("byte_out mismatch: expected 0x%02h, actual 0x%02h",
                           w.byte_val, m_byte_out);
                    error_count++;
                end
                if (m_is_data !== w.is_data) begin
                    $error("is_data mismatch: expected %0b, actual %0b", w.is_data, m_is_data);
                    error_count++;
                end
                if (m_last !== w.last) begin
                    $error("last mismatch: expected %0b, actual %0b", w.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: reset, directed table, random requests, drain.
    initial begin
        int drain;
        error_count = 0;
        words_checked = 0;
        n_char = 0;
        n_cursor = 0;
        n_raw = 0;
        n_dropped = 0;
        rx_steady = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = gcg_pkg::MODE_CHAR;
        s_code = 8'h00;
        s_attribute = 8'h00;
        s_row = 3'd0;
        s_column = 7'd0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Blank cell plain and inverted, range ends, decorations, cursor and raw requests, drops.
        directed.push_back(req(gcg_pkg::MODE_CHAR, gcg_pkg::FIRST_CODE, 8'h00, 3'd0, 7'd0,
                               4'd6, 48'h0, 1'b1));
        directed.push_back(req(gcg_pkg::MODE_CHAR, gcg_pkg::FIRST_CODE, gcg_pkg::INVERT_ATTR,
                               3'd7, 7'd127, 4'd6, 48'hFFFFFFFFFFFF, 1'b1));
        directed.push_back(req(gcg_pkg::MODE_CHAR, gcg_pkg::LAST_CODE, 8'h00, 3'd0, 7'd0,
                               PREDICTED, 48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, gcg_pkg::LAST_CODE, gcg_pkg::INVERT_ATTR,
                               3'd0, 7'd0, PREDICTED, 48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h41, 8'h80, 3'd2, 7'd9, PREDICTED,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h41, 8'h08, 3'd0, 7'd0, PREDICTED,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h41, 8'h01, 3'd0, 7'd0, PREDICTED,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h7A, 8'hFE, 3'd0, 7'd0, PREDICTED,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h30, 8'h7F, 3'd0, 7'd0, PREDICTED,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h21, 8'h55, 3'd5, 7'd85, PREDICTED,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, gcg_pkg::FIRST_CODE - 1, 8'h00, 3'd0, 7'd0,
                               4'd0, 48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, gcg_pkg::LAST_CODE + 1, 8'h00, 3'd0, 7'd0,
                               4'd0, 48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'h00, 8'h00, 3'd0, 7'd0, 4'd0,
                               48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CHAR, 8'hFF, gcg_pkg::INVERT_ATTR, 3'd7, 7'd127,
                               4'd0, 48'h0, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CURSOR, 8'h00, 8'h00, 3'd0, 7'd0, 4'd2,
                               48'h804000000000, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CURSOR, 8'hFF, gcg_pkg::INVERT_ATTR, 3'd7, 7'd127,
                               4'd2, 48'hFF4700000000, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_CURSOR, 8'h41, 8'h12, 3'd5, 7'h55, 4'd2,
                               48'hD54500000000, 1'b0));
        directed.push_back(req(gcg_pkg::MODE_RAW, 8'h00, 8'h00, 3'd0, 7'd0, 4'd1,
                               48'h0, 1'b1));
        directed.push_back(req(gcg_pkg::MODE_RAW, 8'hFF, 8'h00, 3'd7, 7'd127, 4'd1,
                               48'hFF0000000000, 1'b1));
        directed.push_back(req(gcg_pkg::MODE_RAW, 8'hA5, gcg_pkg::INVERT_ATTR, 3'd2, 7'd3,
                               4'd1, 48'hA50000000000, 1'b1));
        directed.push_back(req(MODE_UNUSED, 8'h41, 8'h00, 3'd0, 7'd0, 4'd0, 48'h0, 1'b0));
        directed.push_back(req(MODE_UNUSED, 8'hFF, 8'hFF, 3'd7, 7'd127, 4'd0, 48'h0, 1'b0));

        foreach (directed[i]) begin
            send_request(directed[i]);
            idle_sender(rand_gap());
        end

        // Random requests; one pause in the middle until every expected word has
        // drained, and a back-to-back stretch with a steady receiver later on.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == RANDOM_REQUESTS / 2) begin
                idle_sender(1);
                while (pending_ctrl_words.size() != 0) @(posedge aclk);
            end
            rx_steady = (i >= 180 && i < 220);
            send_request(random_request());
            if (!rx_steady) idle_sender(rand_gap());
        end

        // Drain with the receiver always ready, then watch for stray words.
        idle_sender(1);
        rx_steady = 1'b1;
        drain = 0;
        while (pending_ctrl_words.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_ctrl_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_ctrl_words.size());
            error_count++;
        end

        $display("Requests taken: %0d character, %0d cursor, %0d raw, %0d dropped.",
                 n_char, n_cursor, n_raw, n_dropped);
        $display("Words checked on the output channel: %0d, errors: %0d.",
                 words_checked, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
